>>> design/bmpc_pkg.sv
package bmpc_pkg;

  // Header layout (byte positions in the file)
  localparam int unsigned HeaderEnd    = 24;
  localparam logic [4:0]  PosSize0     = 5'd2;
  localparam logic [4:0]  PosSize1     = 5'd3;
  localparam logic [4:0]  PosSize2     = 5'd4;
  localparam logic [4:0]  PosSize3     = 5'd5;
  localparam logic [4:0]  PosOffsetLo  = 5'd10;
  localparam logic [4:0]  PosOffsetHi  = 5'd11;
  localparam logic [4:0]  PosWidthLo   = 5'd18;
  localparam logic [4:0]  PosWidthHi   = 5'd19;
  localparam logic [4:0]  PosHeightLo  = 5'd22;
  localparam logic [4:0]  PosHeightHi  = 5'd23;

  // Color packing
  localparam int unsigned RedLsb   = 11;
  localparam int unsigned GreenLsb = 6;
  localparam int unsigned BlueLsb  = 1;

  // Configuration register indexes
  localparam logic CfgOriginX = 1'b0;
  localparam logic CfgOriginY = 1'b1;

  localparam int unsigned CfgWidth   = 10;
  localparam int unsigned PixelWidth = 17;
  localparam int unsigned DivSteps   = 32;

  typedef enum logic [0:0] {
    ST_STREAM,
    ST_DIVIDE
  } bmpc_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input beat accepted this cycle
    logic div_step;  // advance the row-length divider by one bit
  } bmpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_last;    // current byte is the last height byte
    logic div_last;    // divider is on its final bit
    logic out_blocked; // output register full and stalled
  } bmpc_status_t;

endpackage

>>> design/bmpc_ctrl.sv
module bmpc_ctrl
  import bmpc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  bmpc_status_t status_i,
  output bmpc_cmd_t    cmd_o
);

  bmpc_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STREAM;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_STREAM: begin
        if (cmd_o.take && status_i.hdr_last) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = ST_STREAM;
        end
      end
      default: state_d = ST_STREAM;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o     = 1'b1;
    cmd_o.div_step = 1'b0;
    case (state_q)
      ST_STREAM: begin
        in_stall_o = status_i.out_blocked;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    cmd_o.take = in_valid_i & ~in_stall_o;
  end

endmodule

>>> design/bmpc_datapath.sv
module bmpc_datapath
  import bmpc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [7:0]              in_file_byte_i,
  input  logic                    in_new_file_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CfgWidth-1:0]     cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PixelWidth-1:0]   out_pixel_x_o,
  output logic [PixelWidth-1:0]   out_pixel_y_o,
  output logic [15:0]             out_color_o,
  input  bmpc_cmd_t               cmd_i,
  output bmpc_status_t            status_o
);

  logic [CfgWidth-1:0] origin_x_q, origin_y_q;
  logic [31:0] byte_offset_q, byte_offset_d;
  logic [31:0] file_size_q, file_size_d;
  logic [15:0] data_offset_q, data_offset_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [7:0]  blue_q, blue_d;
  logic [7:0]  green_q, green_d;
  logic [1:0]  phase_q, phase_d;

  // divider: quotient shifts in over the dividend, remainder stays below height
  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [4:0]  div_cnt_q, div_cnt_d;
  logic [16:0] rem_shift;
  logic        rem_ge;
  logic        div_load;

  logic        out_valid_q, out_valid_d;
  logic [PixelWidth-1:0] pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic [15:0] color_q, color_d;

  logic [31:0] pos;
  logic        in_header;
  logic        in_data;
  logic        emit;
  logic        out_take;

  // base values seen by this byte; a new file starts from a clean parse
  logic [31:0] fs_b;
  logic [15:0] doff_b, w_b, h_b, col_b, row_b;
  logic [7:0]  blue_b, green_b;
  logic [1:0]  phase_b;

  assign pos     = in_new_file_i ? '0 : byte_offset_q;
  assign fs_b    = in_new_file_i ? '0 : file_size_q;
  assign doff_b  = in_new_file_i ? '0 : data_offset_q;
  assign w_b     = in_new_file_i ? '0 : width_q;
  assign h_b     = in_new_file_i ? '0 : height_q;
  assign col_b   = in_new_file_i ? '0 : col_q;
  assign row_b   = in_new_file_i ? '0 : row_q;
  assign blue_b  = in_new_file_i ? '0 : blue_q;
  assign green_b = in_new_file_i ? '0 : green_q;
  assign phase_b = in_new_file_i ? '0 : phase_q;

  assign in_header = pos < 32'(HeaderEnd);
  assign in_data   = !in_header && (pos >= {16'd0, doff_b}) && (w_b != '0) && (row_b < h_b);
  assign emit      = cmd_i.take && in_data && (phase_b == 2'd2) &&
                     ({16'd0, col_b} < quo_q);
  assign out_take  = out_valid_q && !out_stall_i;

  assign status_o.hdr_last    = in_header && (pos[4:0] == PosHeightHi);
  assign status_o.div_last    = div_cnt_q == 5'(DivSteps - 1);
  assign status_o.out_blocked = out_valid_q && out_stall_i;
  assign div_load             = cmd_i.take && status_o.hdr_last;

  // header capture and pixel assembly
  always_comb begin
    byte_offset_d = byte_offset_q;
    file_size_d   = file_size_q;
    data_offset_d = data_offset_q;
    width_d       = width_q;
    height_d      = height_q;
    col_d         = col_q;
    row_d         = row_q;
    blue_d        = blue_q;
    green_d       = green_q;
    phase_d       = phase_q;
    if (cmd_i.take) begin
      file_size_d   = fs_b;
      data_offset_d = doff_b;
      width_d       = w_b;
      height_d      = h_b;
      col_d         = col_b;
      row_d         = row_b;
      blue_d        = blue_b;
      green_d       = green_b;
      phase_d       = phase_b;
      byte_offset_d = (pos == '1) ? pos : pos + 32'd1;
      if (in_header) begin
        case (pos[4:0])
          PosSize0:    file_size_d[7:0]    = in_file_byte_i;
          PosSize1:    file_size_d[15:8]   = in_file_byte_i;
          PosSize2:    file_size_d[23:16]  = in_file_byte_i;
          PosSize3:    file_size_d[31:24]  = in_file_byte_i;
          PosOffsetLo: data_offset_d[7:0]  = in_file_byte_i;
          PosOffsetHi: data_offset_d[15:8] = in_file_byte_i;
          PosWidthLo:  width_d[7:0]        = in_file_byte_i;
          PosWidthHi:  width_d[15:8]       = in_file_byte_i;
          PosHeightLo: height_d[7:0]       = in_file_byte_i;
          PosHeightHi: height_d[15:8]      = in_file_byte_i;
          default: ;
        endcase
      end else if (in_data) begin
        case (phase_b)
          2'd0: begin
            blue_d  = in_file_byte_i;
            phase_d = 2'd1;
          end
          2'd1: begin
            green_d = in_file_byte_i;
            phase_d = 2'd2;
          end
          default: begin
            phase_d = 2'd0;
            if (col_b + 16'd1 >= w_b) begin
              col_d = '0;
              row_d = row_b + 16'd1;
            end else begin
              col_d = col_b + 16'd1;
            end
          end
        endcase
      end
    end
  end

  // row length divider, one quotient bit per cycle
  assign rem_shift = {rem_q, quo_q[31]};
  assign rem_ge    = rem_shift >= {1'b0, height_q};

  always_comb begin
    quo_d     = quo_q;
    rem_d     = rem_q;
    div_cnt_d = div_cnt_q;
    if (div_load) begin
      quo_d     = fs_b - {16'd0, doff_b};
      rem_d     = '0;
      div_cnt_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d     = rem_ge ? 16'(rem_shift - {1'b0, height_q}) : rem_shift[15:0];
      quo_d     = {quo_q[30:0], rem_ge};
      div_cnt_d = div_cnt_q + 5'd1;
      // zero height gives a zero row length
      if (status_o.div_last && (height_q == '0)) begin
        quo_d = '0;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !out_take;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    color_d     = color_q;
    if (emit) begin
      out_valid_d = 1'b1;
      pix_x_d     = {7'd0, origin_x_q} + {1'b0, col_b};
      pix_y_d     = {7'd0, origin_y_q} + {1'b0, h_b} - 17'd1 - {1'b0, row_b};
      color_d     = '0;
      color_d[RedLsb+:5]   = in_file_byte_i[7:3];
      color_d[GreenLsb+:5] = green_b[7:3];
      color_d[BlueLsb+:5]  = blue_b[7:3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      byte_offset_q <= '0;
      file_size_q   <= '0;
      data_offset_q <= '0;
      width_q       <= '0;
      height_q      <= '0;
      col_q         <= '0;
      row_q         <= '0;
      blue_q        <= '0;
      green_q       <= '0;
      phase_q       <= '0;
      quo_q         <= '0;
      rem_q         <= '0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgOriginX: origin_x_q <= cfg_data_i;
          CfgOriginY: origin_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      byte_offset_q <= byte_offset_d;
      file_size_q   <= file_size_d;
      data_offset_q <= data_offset_d;
      width_q       <= width_d;
      height_q      <= height_d;
      col_q         <= col_d;
      row_q         <= row_d;
      blue_q        <= blue_d;
      green_q       <= green_d;
      phase_q       <= phase_d;
      quo_q         <= quo_d;
      rem_q         <= rem_d;
      div_cnt_q     <= div_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload of the output beat
  always_ff @(posedge clk_i) begin
    pix_x_q <= pix_x_d;
    pix_y_q <= pix_y_d;
    color_q <= color_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_pixel_x_o = pix_x_q;
  assign out_pixel_y_o = pix_y_q;
  assign out_color_o   = color_q;

endmodule

>>> design/bmp_rgb888_to_rgb5551_stream_core.sv
// Channel | Direction | Signals
// --------+-----------+---------------------------------------------------
// in      | sink      | in_valid_i, in_stall_o, in_file_byte_i, in_new_file_i
// out     | source    | out_valid_o, out_stall_i, out_pixel_x_o, out_pixel_y_o,
//         |           | out_color_o
// cfg     | sink      | cfg_we_i, cfg_index_i, cfg_data_i
//
// One file byte per cycle, except the last height byte (byte 23): after it
// the input stalls while a one-bit-per-cycle divider computes the row
// length. Results leave through a single output register; when it is full
// and stalled, the input stalls too. Reset clears the parse state and both
// origin registers.
module bmp_rgb888_to_rgb5551_stream_core
  import bmpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            in_file_byte_i,
  input  logic                  in_new_file_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PixelWidth-1:0] out_pixel_x_o,
  output logic [PixelWidth-1:0] out_pixel_y_o,
  output logic [15:0]           out_color_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CfgWidth-1:0]   cfg_data_i
);

  bmpc_cmd_t    cmd;
  bmpc_status_t status;

  bmpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bmpc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_file_byte_i (in_file_byte_i),
    .in_new_file_i  (in_new_file_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_pixel_x_o  (out_pixel_x_o),
    .out_pixel_y_o  (out_pixel_y_o),
    .out_color_o    (out_color_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

>>> tb/bmp_rgb888_to_rgb5551_stream_core_tb.sv
module bmp_rgb888_to_rgb5551_stream_core_tb;
  import bmpc_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 48;   // divider plus output register
  localparam int unsigned PhaseBytes   = 260;
  localparam int unsigned TargetBytes  = 1100;

  typedef struct packed {
    logic [7:0] data;
    logic       new_file;
  } file_beat_t;

  typedef struct packed {
    logic [PixelWidth-1:0] x;
    logic [PixelWidth-1:0] y;
    logic [15:0]           color;
  } screen_pixel_t;

  // DUT connections, all inputs known from time zero
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            in_file_byte_i = '0;
  logic                  in_new_file_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [PixelWidth-1:0] out_pixel_x_o;
  logic [PixelWidth-1:0] out_pixel_y_o;
  logic [15:0]           out_color_o;
  logic                  cfg_we_i       = 1'b0;
  logic                  cfg_index_i    = CfgOriginX;
  logic [CfgWidth-1:0]   cfg_data_i     = '0;

  // Stimulus and expectation stores
  file_beat_t    byte_q[$];
  screen_pixel_t pixel_expect_q[$];

  // Shadow of the parser
  logic [CfgWidth-1:0] origin_x_q = '0;
  logic [CfgWidth-1:0] origin_y_q = '0;
  logic [31:0]         file_pos   = '0;
  logic [31:0]         file_size  = '0;
  logic [15:0]         data_off   = '0;
  logic [15:0]         img_w      = '0;
  logic [15:0]         img_h      = '0;
  logic [31:0]         row_len    = '0;
  logic [31:0]         col_idx    = '0;
  logic [31:0]         row_idx    = '0;
  logic [7:0]          blue_q     = '0;
  logic [7:0]          green_q    = '0;
  logic [1:0]          lane_idx   = '0;

  // Run bookkeeping
  bit          beat_taken = 1'b0;
  bit          quiet      = 1'b0;
  bit          long_hold  = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned hold_gap   = 0;
  int unsigned cycles     = 0;
  int unsigned errors     = 0;
  int unsigned beats_in   = 0;
  int unsigned pixels_out = 0;
  int unsigned in_held    = 0;
  int unsigned bytes_queued = 0;
  int unsigned files_queued = 0;
  int unsigned settings   = 0;

  bmp_rgb888_to_rgb5551_stream_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_file_byte_i (in_file_byte_i),
    .in_new_file_i  (in_new_file_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_pixel_x_o  (out_pixel_x_o),
    .out_pixel_y_o  (out_pixel_y_o),
    .out_color_o    (out_color_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
  endfunction

  // Advance the parser shadow by one file byte; queue the pixel it yields
  function automatic void predict_file_byte(logic [7:0] fb, logic nf);
    logic [31:0]   pos;
    screen_pixel_t px;
    if (nf) begin
      file_pos  = '0;
      file_size = '0;
      data_off  = '0;
      img_w     = '0;
      img_h     = '0;
      row_len   = '0;
      col_idx   = '0;
      row_idx   = '0;
      blue_q    = '0;
      green_q   = '0;
      lane_idx  = '0;
    end
    pos = file_pos;
    if (pos < HeaderEnd) begin
      case (pos[4:0])
        PosSize0:    file_size[7:0]   = fb;
        PosSize1:    file_size[15:8]  = fb;
        PosSize2:    file_size[23:16] = fb;
        PosSize3:    file_size[31:24] = fb;
        PosOffsetLo: data_off[7:0]    = fb;
        PosOffsetHi: data_off[15:8]   = fb;
        PosWidthLo:  img_w[7:0]       = fb;
        PosWidthHi:  img_w[15:8]      = fb;
        PosHeightLo: img_h[7:0]       = fb;
        PosHeightHi: begin
          img_h[15:8] = fb;
          row_len = (img_h == 0) ? '0 : (file_size - 32'(data_off)) / 32'(img_h);
        end
        default: ;
      endcase
    end else if (pos >= 32'(data_off) && img_w != 0 && row_idx < 32'(img_h)) begin
      case (lane_idx)
        2'd0: begin
          blue_q   = fb;
          lane_idx = 2'd1;
        end
        2'd1: begin
          green_q  = fb;
          lane_idx = 2'd2;
        end
        default: begin
          if (col_idx < row_len) begin
            px.x     = PixelWidth'(32'(origin_x_q) + col_idx);
            px.y     = PixelWidth'(32'(origin_y_q) + 32'(img_h) - 32'd1 - row_idx);
            px.color = {fb[7:3], green_q[7:3], blue_q[7:3], 1'b0};
            pixel_expect_q.push_back(px);
          end
          lane_idx = 2'd0;
          col_idx  = col_idx + 1;
          if (col_idx >= 32'(img_w)) begin
            col_idx = '0;
            row_idx = row_idx + 1;
          end
        end
      endcase
    end
    if (file_pos != '1) file_pos = file_pos + 1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, want, want, got, got);
    end
  endfunction

  // Output check, register shadow and prediction, all on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        pixels_out++;
        if (pixel_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel: expected none, got x=%0d y=%0d color=0x%0h",
                   $time, out_pixel_x_o, out_pixel_y_o, out_color_o);
        end else begin
          check_field("pixel_x", 32'(pixel_expect_q[0].x), 32'(out_pixel_x_o));
          check_field("pixel_y", 32'(pixel_expect_q[0].y), 32'(out_pixel_y_o));
          check_field("color", 32'(pixel_expect_q[0].color), 32'(out_color_o));
          void'(pixel_expect_q.pop_front());
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CfgOriginX) origin_x_q = cfg_data_i;
        else if (cfg_index_i == CfgOriginY) origin_y_q = cfg_data_i;
      end
      if (in_valid_i && in_stall_o === 1'b0) begin
        beats_in++;
        predict_file_byte(in_file_byte_i, in_new_file_i);
      end
      if (in_valid_i && in_stall_o === 1'b1) in_held++;
    end
    beat_taken <= rst_ni && in_valid_i && in_stall_o === 1'b0;
  end

  // Byte driver: one beat at a time from the pending queue, random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      if (beat_taken && !quiet && $urandom_range(0, 3) == 0) send_gap = idle_len();
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_valid_i     <= 1'b1;
        in_file_byte_i <= byte_q[0].data;
        in_new_file_i  <= byte_q[0].new_file;
        void'(byte_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Pixel sink: random stall bursts plus the long hold-off
  always @(negedge clk_i) begin
    if (hold_gap != 0) hold_gap--;
    else if (!quiet && $urandom_range(0, 4) == 0) hold_gap = idle_len();
    out_stall_i <= long_hold || (hold_gap != 0);
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d pixels still outstanding",
               $time, cycles, pixel_expect_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Hold the sink off while the sender still has plenty queued
  initial begin
    while (!(beats_in >= 200 && byte_q.size() >= 40)) @(posedge clk_i);
    long_hold = 1'b1;
    repeat (200) @(posedge clk_i);
    long_hold = 1'b0;
  end

  function automatic void push_file_byte(logic [7:0] v, logic nf);
    file_beat_t fbt;
    fbt.data     = v;
    fbt.new_file = nf;
    byte_q.push_back(fbt);
    bytes_queued++;
  endfunction

  // One 2x1 file sent without a start flag right after reset, data offset
  // inside the header, ignored header bytes all ones, black and white pixels
  function automatic void queue_directed_file();
    logic [7:0] hdr [24];
    for (int i = 0; i < 24; i++) hdr[i] = 8'hFF;
    {hdr[5], hdr[4], hdr[3], hdr[2]} = 32'd6;
    {hdr[11], hdr[10]} = 16'd0;
    {hdr[19], hdr[18]} = 16'd2;
    {hdr[23], hdr[22]} = 16'd1;
    for (int i = 0; i < 24; i++) push_file_byte(hdr[i], 1'b0);
    for (int i = 0; i < 3; i++) push_file_byte(8'h00, 1'b0);
    for (int i = 0; i < 3; i++) push_file_byte(8'hFF, 1'b0);
    files_queued++;
  endfunction

  // Mostly well-formed small images; the rest covers odd headers,
  // cut-off files, stray bytes and trailing junk
  function automatic void queue_random_file();
    logic [7:0]  hdr [24];
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] off;
    logic [31:0] fsize;
    int unsigned kind;
    int unsigned pix_len;
    int unsigned body;
    int unsigned pad;
    int unsigned tail;
    kind = $urandom_range(0, 19);
    w    = 16'($urandom_range(1, 7));
    h    = 16'($urandom_range(1, 5));
    off  = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 40)) : 16'd54;
    case (kind)
      0: w = '0;
      1: h = '0;
      2: begin
        w = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(8, 65535));
        h = 16'($urandom_range(1, 2));
      end
      3: h = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(6, 65535));
      default: ;
    endcase
    pix_len = (w > 7 || h > 5) ? 0 : 3 * w * h;
    body    = (w > 7 || h > 5 || w == 0 || h == 0) ? $urandom_range(6, 30) : pix_len;
    case ($urandom_range(0, 5))
      0: fsize = 32'(off) + $urandom_range(0, pix_len);  // rows clipped short
      1: fsize = $urandom_range(0, off);                 // size at or below offset
      2: fsize = $urandom();
      default: fsize = 32'(off) + pix_len;
    endcase
    tail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    if (kind == 4) begin
      body = $urandom_range(0, body);  // cut off, the next file restarts
      tail = 0;
    end
    pad = (off > 24) ? off - 24 : 0;
    for (int i = 0; i < 24; i++) hdr[i] = 8'($urandom());
    {hdr[5], hdr[4], hdr[3], hdr[2]} = fsize;
    {hdr[11], hdr[10]} = off;
    {hdr[19], hdr[18]} = w;
    {hdr[23], hdr[22]} = h;
    // stray bytes without a start flag land on the previous file
    if (kind == 5) begin
      for (int i = $urandom_range(1, 5); i > 0; i--) push_file_byte(8'($urandom()), 1'b0);
    end
    for (int i = 0; i < 24; i++) push_file_byte(hdr[i], i == 0);
    for (int i = 0; i < pad + body + tail; i++) push_file_byte(8'($urandom()), 1'b0);
    files_queued++;
  endfunction

  task automatic set_origin(logic [CfgWidth-1:0] ox, logic [CfgWidth-1:0] oy);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgOriginX;
    cfg_data_i  <= ox;
    @(negedge clk_i);
    cfg_index_i <= CfgOriginY;
    cfg_data_i  <= oy;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    settings++;
  endtask

  // Wait for every queued byte and every pixel, then let the divider settle
  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid_i || pixel_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Phases: origin setting, then a batch of files
  initial begin
    int unsigned phase;
    int unsigned phase_start;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    phase = 0;
    while (bytes_queued < TargetBytes) begin
      @(posedge clk_i);
      quiet = (phase % 3 == 2);
      case (phase)
        0: set_origin('0, '0);
        1: set_origin('1, '1);
        2: set_origin('1, '0);
        3: set_origin('0, '1);
        default: set_origin(CfgWidth'($urandom()), CfgWidth'($urandom()));
      endcase
      phase_start = bytes_queued;
      if (phase == 0) queue_directed_file();
      else while (bytes_queued - phase_start < PhaseBytes) queue_random_file();
      wait_idle();
      phase++;
    end
    $display("Run covered %0d file bytes in %0d files under %0d origin settings.",
             beats_in, files_queued, settings);
    $display("%0d pixels compared; input held off for %0d cycles.", pixels_out, in_held);
    if (errors == 0 && pixel_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
